### design/i2cms_pkg.sv
`default_nettype none
package i2cms_pkg;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd20;
  localparam logic [3:0] BYTE_BITS = 4'd8;
  localparam logic [2:0] TIMER_MAX = 3'd5;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_START    = 3'd1,
    OP_STOP     = 3'd2,
    OP_WRITE    = 3'd3,
    OP_READ     = 3'd4,
    OP_ACK      = 3'd5,
    OP_NACK     = 3'd6,
    OP_WAIT_ACK = 3'd7
  } op_e;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_ST_A      = 5'd1,
    PH_ST_B      = 5'd2,
    PH_SP_A      = 5'd3,
    PH_SP_B      = 5'd4,
    PH_AK_A      = 5'd5,
    PH_AK_B      = 5'd6,
    PH_NK_A      = 5'd7,
    PH_NK_B      = 5'd8,
    PH_WR_LO     = 5'd9,
    PH_WR_HI     = 5'd10,
    PH_RD_LO     = 5'd11,
    PH_RD_HI     = 5'd12,
    PH_WA_A      = 5'd13,
    PH_WA_B      = 5'd14,
    PH_WA_POLL   = 5'd15,
    PH_WA_TAIL   = 5'd16,
    PH_DONE      = 5'd17,
    PH_DONE_MISS = 5'd18
  } phase_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data_byte;
    logic       sda_sample;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_missing;
  } res_t;

  typedef struct packed {
    logic       scl;
    logic       drv;
    logic       sda;
    logic [2:0] timer;
  } lines_t;

endpackage
`default_nettype wire

### design/i2c_master_bit_sequencer_unit.sv
// request registered in in_q; result registered in out_q when the sequencer steps
// throughput: one request per cycle; the line sequencer steps once per request
// stall on the request side only when a result is held and out_stall_i is high
// reset: asynchronous active low; idle, scl low, sda driven low, ack_timeout 20
`default_nettype none
module i2c_master_bit_sequencer_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire i2cms_pkg::req_t in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output i2cms_pkg::res_t      out_data_o,
  input  wire logic            cfg_we_i,
  input  wire logic [7:0]      cfg_wdata_i
);
  import i2cms_pkg::*;

  req_t       in_q;
  logic       in_vld_q, in_vld_d;
  res_t       res, out_q;
  logic       out_vld_q, out_vld_d;
  logic [7:0] ack_timeout_q;
  logic       step_en, accept;

  assign step_en    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !step_en;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (step_en) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (step_en) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
      ack_timeout_q <= ACK_TIMEOUT_RST;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        ack_timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (step_en) begin
      out_q <= res;
    end
  end

  i2cms_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_en_i     (step_en),
    .req_i         (in_q),
    .ack_timeout_i (ack_timeout_q),
    .res_o         (res)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

### design/i2cms_seq.sv
`default_nettype none
module i2cms_seq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_en_i,
  input  wire i2cms_pkg::req_t req_i,
  input  wire logic [7:0]      ack_timeout_i,
  output i2cms_pkg::res_t      res_o
);
  import i2cms_pkg::*;

  phase_e     phase_q, phase_d, st_phase, nxt_phase;
  op_e        cmd_q, cmd_d, st_cmd;
  logic [3:0] bi_q, bi_d, st_bi;
  logic [7:0] pc_q, pc_d, st_pc;
  logic [7:0] sh_q, sh_d, st_sh;
  lines_t     lines_q, lines_d, st_lines;
  logic [2:0] tm_dec;
  logic [7:0] limit;

  function automatic phase_e first_phase(op_e op);
    phase_e p;
    begin
      unique case (op)
        OP_START:    p = PH_ST_A;
        OP_STOP:     p = PH_SP_A;
        OP_WRITE:    p = PH_WR_LO;
        OP_READ:     p = PH_RD_LO;
        OP_ACK:      p = PH_AK_A;
        OP_NACK:     p = PH_NK_A;
        OP_WAIT_ACK: p = PH_WA_A;
        default:     p = PH_IDLE;
      endcase
      return p;
    end
  endfunction

  function automatic lines_t enter_lines(phase_e p, op_e cmd, logic [7:0] sh, logic sda);
    lines_t l;
    begin
      unique case (p)
        PH_ST_A:    l = '{1'b1, 1'b1, 1'b1, 3'd2};
        PH_ST_B:    l = '{1'b1, 1'b1, 1'b0, 3'd1};
        PH_SP_A:    l = '{1'b1, 1'b1, 1'b0, 3'd2};
        PH_SP_B:    l = '{1'b1, 1'b1, 1'b1, 3'd1};
        PH_AK_A:    l = '{1'b0, 1'b1, 1'b0, 3'd2};
        PH_AK_B:    l = '{1'b1, 1'b1, 1'b0, 3'd3};
        PH_NK_A:    l = '{1'b0, 1'b1, 1'b1, 3'd1};
        PH_NK_B:    l = '{1'b1, 1'b1, 1'b1, 3'd1};
        PH_WR_LO:   l = '{1'b0, 1'b1, sh[7], 3'd2};
        PH_WR_HI:   l = '{1'b1, 1'b1, sda, 3'd5};
        PH_RD_LO:   l = '{1'b0, 1'b0, sda, 3'd5};
        PH_RD_HI:   l = '{1'b1, 1'b0, sda, 3'd2};
        PH_WA_A:    l = '{1'b0, 1'b1, 1'b1, 3'd1};
        PH_WA_B:    l = '{1'b0, 1'b0, 1'b1, 3'd1};
        PH_WA_POLL: l = '{1'b1, 1'b0, sda, 3'd0};
        PH_WA_TAIL: l = '{1'b0, 1'b1, 1'b1, 3'd1};
        default: begin
          if (cmd == OP_START || cmd == OP_ACK || cmd == OP_NACK) begin
            l = '{1'b0, 1'b1, 1'b0, 3'd0};
          end else if (cmd == OP_STOP) begin
            l = '{1'b0, 1'b1, 1'b1, 3'd0};
          end else begin
            l = '{1'b0, 1'b1, sda, 3'd0};
          end
        end
      endcase
      return l;
    end
  endfunction

  assign limit = (ack_timeout_i == 8'd0) ? 8'd1 : ack_timeout_i;

  // command entry when idle
  always_comb begin
    st_phase = phase_q;
    st_cmd   = cmd_q;
    st_bi    = bi_q;
    st_pc    = pc_q;
    st_sh    = sh_q;
    st_lines = lines_q;
    if (phase_q == PH_IDLE && req_i.op != OP_TICK) begin
      st_cmd   = req_i.op;
      st_bi    = '0;
      st_pc    = '0;
      st_sh    = (req_i.op == OP_WRITE) ? req_i.data_byte : 8'd0;
      st_phase = first_phase(req_i.op);
      st_lines = enter_lines(st_phase, req_i.op, st_sh, lines_q.sda);
    end
  end

  // next state
  always_comb begin
    phase_d   = st_phase;
    cmd_d     = st_cmd;
    bi_d      = st_bi;
    pc_d      = st_pc;
    sh_d      = st_sh;
    lines_d   = st_lines;
    nxt_phase = PH_DONE;
    tm_dec    = st_lines.timer;
    priority if (st_phase == PH_IDLE) begin
    end else if (st_phase == PH_DONE || st_phase == PH_DONE_MISS) begin
      phase_d = PH_IDLE;
    end else if (st_phase == PH_WA_POLL) begin
      if (!req_i.sda_sample) begin
        phase_d = PH_DONE;
        lines_d = enter_lines(PH_DONE, st_cmd, st_sh, st_lines.sda);
      end else begin
        pc_d = (st_pc != 8'hFF) ? st_pc + 8'd1 : st_pc;
        if (pc_d >= limit) begin
          phase_d = PH_SP_A;
          lines_d = enter_lines(PH_SP_A, st_cmd, st_sh, st_lines.sda);
        end
      end
    end else begin
      if (st_phase == PH_RD_HI && st_lines.timer == 3'd2) begin
        sh_d = {st_sh[6:0], req_i.sda_sample};
      end
      if (tm_dec != 3'd0) begin
        tm_dec = tm_dec - 3'd1;
      end
      lines_d.timer = tm_dec;
      if (tm_dec == 3'd0) begin
        unique case (st_phase)
          PH_ST_A:    nxt_phase = PH_ST_B;
          PH_SP_A:    nxt_phase = PH_SP_B;
          PH_SP_B:    nxt_phase = (st_cmd == OP_WAIT_ACK) ? PH_WA_TAIL : PH_DONE;
          PH_AK_A:    nxt_phase = PH_AK_B;
          PH_NK_A:    nxt_phase = PH_NK_B;
          PH_WR_LO:   nxt_phase = PH_WR_HI;
          PH_WR_HI: begin
            sh_d      = {sh_d[6:0], 1'b0};
            bi_d      = st_bi + 4'd1;
            nxt_phase = (bi_d >= BYTE_BITS) ? PH_DONE : PH_WR_LO;
          end
          PH_RD_LO:   nxt_phase = PH_RD_HI;
          PH_RD_HI: begin
            bi_d      = st_bi + 4'd1;
            nxt_phase = (bi_d >= BYTE_BITS) ? PH_DONE : PH_RD_LO;
          end
          PH_WA_A:    nxt_phase = PH_WA_B;
          PH_WA_B:    nxt_phase = PH_WA_POLL;
          PH_WA_TAIL: nxt_phase = PH_DONE_MISS;
          default:    nxt_phase = PH_DONE;
        endcase
        phase_d = nxt_phase;
        lines_d = enter_lines(nxt_phase, st_cmd, sh_d, st_lines.sda);
      end
    end
  end

  // result
  always_comb begin
    res_o.scl_level   = st_lines.scl;
    res_o.sda_drive   = st_lines.drv;
    res_o.sda_level   = st_lines.sda;
    res_o.done_res    = (st_phase == PH_DONE) || (st_phase == PH_DONE_MISS);
    res_o.busy_res    = (st_phase != PH_IDLE) && !res_o.done_res;
    res_o.read_byte   = (res_o.done_res && st_cmd == OP_READ) ? st_sh : 8'd0;
    res_o.ack_missing = (st_phase == PH_DONE_MISS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cmd_q   <= OP_TICK;
      bi_q    <= '0;
      pc_q    <= '0;
      sh_q    <= '0;
      lines_q <= '{1'b0, 1'b1, 1'b0, 3'd0};
    end else if (step_en_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      bi_q    <= bi_d;
      pc_q    <= pc_d;
      sh_q    <= sh_d;
      lines_q <= lines_d;
    end
  end

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && res_o.done_res |=> phase_q == PH_IDLE)
    else $error("sequencer not idle after done");
  a_miss_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.ack_missing |-> res_o.done_res && st_cmd == OP_WAIT_ACK)
    else $error("ack missing outside wait-ack done");
  a_timer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lines_q.timer <= TIMER_MAX)
    else $error("delay timer out of range");
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bi_q <= BYTE_BITS)
    else $error("bit index out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_en_i |=> $stable(phase_q) && $stable(lines_q))
    else $error("state moved without a request");

endmodule
`default_nettype wire
